@@ sv/csc_pkg.sv @@
package csc_pkg;

   localparam int StepCount  = 16;
   localparam int AtanCount  = 18;
   localparam int StepW      = $clog2(AtanCount);
   localparam int AngleW     = 28;
   localparam int ValueW     = 20;
   localparam int FracW      = 18;

   typedef logic [StepW-1:0] step_type;

   typedef struct packed {
      logic signed [ValueW-1:0] x;
      logic signed [ValueW-1:0] y;
      logic signed [AngleW-1:0] z;
   } vec_type;

   // floor(atan(2^-i) * 2^26)
   localparam logic signed [AngleW-1:0] AtanTable [AtanCount] = '{
      28'sd52707178, 28'sd31114864, 28'sd16440239, 28'sd8345322,
      28'sd4188855,  28'sd2096469,  28'sd1048490,  28'sd524277,
      28'sd262142,   28'sd131071,   28'sd65535,    28'sd32767,
      28'sd16383,    28'sd8191,     28'sd4095,     28'sd2047,
      28'sd1023,     28'sd511
   };

   localparam logic signed [ValueW-1:0] XStart = ValueW'(1 << FracW);

   // K^2 with 60 fraction bits after n steps: each step scales by 1/(1 + 4^-i), rounded up
   localparam logic [63:0] GainSq0  = 64'd1 << 60;
   localparam logic [63:0] GainSq1  = GainSq0  - GainSq0  / ((64'd1 << 0)  + 64'd1);
   localparam logic [63:0] GainSq2  = GainSq1  - GainSq1  / ((64'd1 << 2)  + 64'd1);
   localparam logic [63:0] GainSq3  = GainSq2  - GainSq2  / ((64'd1 << 4)  + 64'd1);
   localparam logic [63:0] GainSq4  = GainSq3  - GainSq3  / ((64'd1 << 6)  + 64'd1);
   localparam logic [63:0] GainSq5  = GainSq4  - GainSq4  / ((64'd1 << 8)  + 64'd1);
   localparam logic [63:0] GainSq6  = GainSq5  - GainSq5  / ((64'd1 << 10) + 64'd1);
   localparam logic [63:0] GainSq7  = GainSq6  - GainSq6  / ((64'd1 << 12) + 64'd1);
   localparam logic [63:0] GainSq8  = GainSq7  - GainSq7  / ((64'd1 << 14) + 64'd1);
   localparam logic [63:0] GainSq9  = GainSq8  - GainSq8  / ((64'd1 << 16) + 64'd1);
   localparam logic [63:0] GainSq10 = GainSq9  - GainSq9  / ((64'd1 << 18) + 64'd1);
   localparam logic [63:0] GainSq11 = GainSq10 - GainSq10 / ((64'd1 << 20) + 64'd1);
   localparam logic [63:0] GainSq12 = GainSq11 - GainSq11 / ((64'd1 << 22) + 64'd1);
   localparam logic [63:0] GainSq13 = GainSq12 - GainSq12 / ((64'd1 << 24) + 64'd1);
   localparam logic [63:0] GainSq14 = GainSq13 - GainSq13 / ((64'd1 << 26) + 64'd1);
   localparam logic [63:0] GainSq15 = GainSq14 - GainSq14 / ((64'd1 << 28) + 64'd1);
   localparam logic [63:0] GainSq16 = GainSq15 - GainSq15 / ((64'd1 << 30) + 64'd1);
   localparam logic [63:0] GainSq17 = GainSq16 - GainSq16 / ((64'd1 << 32) + 64'd1);
   localparam logic [63:0] GainSq18 = GainSq17 - GainSq17 / ((64'd1 << 34) + 64'd1);

   localparam logic [63:0] GainSqTable [AtanCount+1] = '{
      GainSq0,  GainSq1,  GainSq2,  GainSq3,  GainSq4,  GainSq5,  GainSq6,
      GainSq7,  GainSq8,  GainSq9,  GainSq10, GainSq11, GainSq12, GainSq13,
      GainSq14, GainSq15, GainSq16, GainSq17, GainSq18
   };

   // floor(K * 2^18) by integer square root of K^2 * 2^36, evaluated at elaboration
   function automatic logic [ValueW-1:0] gain_k(logic [63:0] ksq);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] c;
      v = ksq >> 24;
      r = '0;
      for (int b = ValueW - 1; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= v) begin
            r = c;
         end
      end
      return r[ValueW-1:0];
   endfunction

   localparam logic [ValueW-1:0] GainK = gain_k(GainSqTable[StepCount]);

endpackage

@@ sv/csc_stage.sv @@
module csc_stage
   import csc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  step_type step,
   input  logic     in_valid,
   output logic     in_ready,
   input  vec_type  in_vec,
   output logic     out_valid,
   input  logic     out_ready,
   output vec_type  out_vec
);

   logic    valid_ff, valid_in;
   vec_type vec_ff, vec_in;

   logic signed [ValueW:0]   ext_x, ext_y, neg_x, neg_y, sh_x, sh_y;
   logic signed [AngleW-1:0] atan_val;
   logic                     z_pos;

   always_comb begin
      z_pos    = !in_vec.z[AngleW-1];
      atan_val = AtanTable[step];
      ext_x    = {in_vec.x[ValueW-1], in_vec.x};
      ext_y    = {in_vec.y[ValueW-1], in_vec.y};
      neg_x    = -ext_x;
      neg_y    = -ext_y;
      sh_x     = z_pos ? (ext_x >>> step) : (neg_x >>> step);
      sh_y     = z_pos ? (ext_y >>> step) : (neg_y >>> step);
      vec_in.x = in_vec.x - sh_y[ValueW-1:0];
      vec_in.y = in_vec.y + sh_x[ValueW-1:0];
      // floor of z -/+ atan: table holds floored values, so subtract one more
      vec_in.z = z_pos ? (in_vec.z - atan_val - AngleW'(1)) : (in_vec.z + atan_val);
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

@@ sv/csc_gain.sv @@
module csc_gain
   import csc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  vec_type                  in_vec,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [ValueW-1:0] cos_value,
   output logic signed [ValueW-1:0] sin_value
);

   localparam int ProdW = 2 * ValueW;

   logic                     valid_ff, valid_in;
   logic signed [ValueW-1:0] cos_ff, sin_ff;
   logic signed [ProdW-1:0]  prod_x, prod_y;
   logic signed [ValueW-1:0] k_s;

   assign k_s    = $signed(GainK);
   assign prod_x = ProdW'(in_vec.x) * ProdW'(k_s);
   assign prod_y = ProdW'(in_vec.y) * ProdW'(k_s);

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // drop the 18 fraction bits of K: floor by arithmetic truncation
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         cos_ff <= prod_x[FracW+ValueW-1:FracW];
         sin_ff <= prod_y[FracW+ValueW-1:FracW];
      end
   end

   assign out_valid = valid_ff;
   assign cos_value = cos_ff;
   assign sin_value = sin_ff;

endmodule

@@ sv/cordic_sin_cos_rotation.sv @@
// Pipeline: one register per rotation step, one for the gain multiply.
// Throughput: one item per cycle unless stalled; each stage holds one item and
// refills as its successor takes it, so bubbles close up while the output stalls.
// Reset: synchronous, active high; clears all stage valid bits, data is not reset.
module cordic_sin_cos_rotation
   import csc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [AngleW-1:0] req_angle,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [ValueW-1:0] rsp_cos_value,
   output logic signed [ValueW-1:0] rsp_sin_value
);

   logic    valid_s [StepCount+1];
   logic    ready_s [StepCount+1];
   vec_type vec_s   [StepCount+1];

   assign valid_s[0]   = req_valid;
   assign req_ready    = ready_s[0];
   assign vec_s[0].x   = XStart;
   assign vec_s[0].y   = '0;
   assign vec_s[0].z   = req_angle;

   for (genvar i = 0; i < StepCount; i++) begin : g_step
      csc_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .step      (StepW'(i)),
         .in_valid  (valid_s[i]),
         .in_ready  (ready_s[i]),
         .in_vec    (vec_s[i]),
         .out_valid (valid_s[i+1]),
         .out_ready (ready_s[i+1]),
         .out_vec   (vec_s[i+1])
      );
   end

   csc_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_s[StepCount]),
      .in_ready  (ready_s[StepCount]),
      .in_vec    (vec_s[StepCount]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .cos_value (rsp_cos_value),
      .sin_value (rsp_sin_value)
   );

endmodule
